>>> rtl/amgs_pkg.sv
package amgs_pkg;

  localparam int LABEL_W = 32;

  // input actions
  typedef logic [2:0] action_t;
  localparam action_t ACT_ADD_VERTEX = 3'd0;
  localparam action_t ACT_DEL_VERTEX = 3'd1;
  localparam action_t ACT_ADD_EDGE   = 3'd2;
  localparam action_t ACT_DEL_EDGE   = 3'd3;
  localparam action_t ACT_LIST       = 3'd4;

  // result status
  typedef logic [1:0] status_t;
  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_MISSING = 2'd2;

  // per-cycle command broadcast to every cell
  typedef logic [2:0] cell_op_t;
  localparam cell_op_t OP_HOLD    = 3'd0;
  localparam cell_op_t OP_MATCH   = 3'd1;
  localparam cell_op_t OP_WRITE   = 3'd2;
  localparam cell_op_t OP_COMPACT = 3'd3;
  localparam cell_op_t OP_EDGE    = 3'd4;
  localparam cell_op_t OP_TAP     = 3'd5;
  localparam cell_op_t OP_STEP    = 3'd6;

  typedef struct packed {
    cell_op_t op;
    logic     edge_bit;
  } cell_ctrl_t;

endpackage

>>> rtl/amgs_cell.sv
module amgs_cell
  import amgs_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int SLOT = 0,
  localparam int IW = $clog2(MAX_NODES)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctrl_t           ctrl,
  input  logic [IW-1:0]        sel_a,
  input  logic [IW-1:0]        sel_b,
  input  logic [LABEL_W-1:0]   va,
  input  logic [LABEL_W-1:0]   vb,
  input  logic [LABEL_W-1:0]   nxt_label,
  input  logic [MAX_NODES-1:0] nxt_row,
  input  logic                 nxt_tflag,
  input  logic [LABEL_W-1:0]   nxt_tlabel,
  output logic [LABEL_W-1:0]   label,
  output logic [MAX_NODES-1:0] row,
  output logic                 match_a,
  output logic                 match_b,
  output logic                 row_any,
  output logic                 tflag,
  output logic [LABEL_W-1:0]   tlabel
);

  logic [LABEL_W-1:0]   label_next;
  logic [MAX_NODES-1:0] row_next;
  logic [MAX_NODES-1:0] src;
  logic [MAX_NODES-1:0] src_sh;
  logic                 lifted;
  logic                 hit_a;
  logic                 hit_b;

  assign hit_a  = (IW'(SLOT) == sel_a);
  assign hit_b  = (IW'(SLOT) == sel_b);
  // slots at or above the removed one take their upper neighbor
  assign lifted = (IW'(SLOT) >= sel_a);
  assign src    = lifted ? nxt_row : row;
  assign src_sh = {1'b0, src[MAX_NODES-1:1]};

  always_comb begin
    label_next = label;
    row_next   = row;
    unique case (ctrl.op)
      OP_WRITE: begin
        if (hit_a) label_next = va;
      end
      OP_COMPACT: begin
        if (lifted) label_next = nxt_label;
        // drop the removed column, zero shifts in at the top
        for (int c = 0; c < MAX_NODES; c++) begin
          row_next[c] = (IW'(c) < sel_a) ? src[c] : src_sh[c];
        end
      end
      OP_EDGE: begin
        if (hit_a) row_next[sel_b] = ctrl.edge_bit;
        if (hit_b) row_next[sel_a] = ctrl.edge_bit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      row_any <= 1'b0;
      tflag   <= 1'b0;
    end else begin
      row     <= row_next;
      row_any <= |row_next;
      if (ctrl.op == OP_TAP) begin
        tflag <= row[sel_a];
      end else if (ctrl.op == OP_STEP) begin
        tflag <= nxt_tflag;
      end
    end
  end

  always_ff @(posedge clk) begin
    label <= label_next;
    if (ctrl.op == OP_MATCH) begin
      match_a <= (label == va);
      match_b <= (label == vb);
    end
    if (ctrl.op == OP_TAP) begin
      tlabel <= label;
    end else if (ctrl.op == OP_STEP) begin
      tlabel <= nxt_tlabel;
    end
  end

endmodule

>>> rtl/adjacency_matrix_graph_store_top.sv
// Undirected graph store: up to MAX_NODES vertex labels kept as a compact list, with a
// symmetric adjacency bit matrix. The store is a row of identical cells, one per vertex
// slot; each holds the slot's label and its matrix row, and removal compacts the store by
// having every cell at or above the removed slot take its upper neighbor's contents.
// A command is taken at a rising edge with start high and busy low. Results come out one
// beat at a time on strobe, each valid for exactly one cycle, and the receiver cannot hold
// them off: it must take every beat as it appears. Remove vertex and edge actions scan the
// match bits slot by slot, and list neighbors also scans before neighbor labels drain out
// of the cell chain toward slot 0 one slot per cycle. The result beat of a single-result
// command appears in the first cycle with busy low, and a new command may be started in
// that same cycle.
module adjacency_matrix_graph_store_top
  import amgs_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                action,
  input  logic signed [LABEL_W-1:0] vertex_a,
  input  logic signed [LABEL_W-1:0] vertex_b,
  output logic                      strobe,
  output logic [1:0]                status,
  output logic                      neighbor_valid,
  output logic signed [LABEL_W-1:0] neighbor_label,
  output logic                      last,
  output logic                      no_edges
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_TAP    = 3'd5;
  localparam logic [2:0] S_LIST   = 3'd6;

  logic [2:0]         state;
  logic [CW-1:0]      count;     // live vertices
  logic [CW-1:0]      scan_idx;
  action_t            action_r;
  logic [LABEL_W-1:0] va_r;
  logic [LABEL_W-1:0] vb_r;
  status_t            status_r;
  logic               found_a;
  logic               found_b;
  logic [IW-1:0]      first_a;
  logic [IW-1:0]      last_a;
  logic [IW-1:0]      last_b;

  cell_ctrl_t         ctrl;
  logic [IW-1:0]      sel_a;
  logic [IW-1:0]      sel_b;

  logic [MAX_NODES-1:0] match_a_v;
  logic [MAX_NODES-1:0] match_b_v;
  logic [MAX_NODES-1:0] row_any_v;
  logic [MAX_NODES-1:0] tflag_v;
  logic [LABEL_W-1:0]   label_v  [MAX_NODES];
  logic [LABEL_W-1:0]   tlabel_v [MAX_NODES];
  logic [MAX_NODES-1:0] row_v    [MAX_NODES];

  logic               graph_empty;
  logic               scan_done;
  logic               hit_a;
  logic               hit_b;
  logic               list_last;

  assign busy        = (state != S_IDLE);
  assign graph_empty = ~|row_any_v;
  assign scan_done   = (scan_idx == count);
  assign hit_a       = match_a_v[scan_idx[IW-1:0]];
  assign hit_b       = match_b_v[scan_idx[IW-1:0]];
  // no neighbor left behind the one at the head of the chain
  assign list_last   = ~|tflag_v[MAX_NODES-1:1];

  // command to the cell row for this cycle
  always_comb begin
    ctrl.op       = OP_HOLD;
    ctrl.edge_bit = 1'b0;
    sel_a         = first_a;
    sel_b         = last_b;
    unique case (state)
      S_MATCH: ctrl.op = OP_MATCH;
      S_UPDATE: begin
        unique case (action_r) inside
          ACT_ADD_VERTEX: begin
            if (count != CW'(MAX_NODES)) begin
              ctrl.op = OP_WRITE;
              sel_a   = count[IW-1:0];
            end
          end
          ACT_DEL_VERTEX: ctrl.op = OP_COMPACT;
          ACT_ADD_EDGE, ACT_DEL_EDGE: begin
            ctrl.op       = OP_EDGE;
            ctrl.edge_bit = (action_r == ACT_ADD_EDGE);
            sel_a         = last_a;
          end
          default: ;
        endcase
      end
      S_TAP:  ctrl.op = OP_TAP;
      S_LIST: ctrl.op = OP_STEP;
      default: ;
    endcase
  end

  // the cell row, each slot fed by the slot above it
  for (genvar s = 0; s < MAX_NODES; s++) begin : g_cell
    logic [LABEL_W-1:0]   up_label;
    logic [MAX_NODES-1:0] up_row;
    logic                 up_tflag;
    logic [LABEL_W-1:0]   up_tlabel;

    if (s < MAX_NODES - 1) begin : g_up
      assign up_label  = label_v[s+1];
      assign up_row    = row_v[s+1];
      assign up_tflag  = tflag_v[s+1];
      assign up_tlabel = tlabel_v[s+1];
    end else begin : g_top
      assign up_label  = '0;
      assign up_row    = '0;
      assign up_tflag  = 1'b0;
      assign up_tlabel = '0;
    end

    amgs_cell #(
      .MAX_NODES (MAX_NODES),
      .SLOT      (s)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .sel_a      (sel_a),
      .sel_b      (sel_b),
      .va         (va_r),
      .vb         (vb_r),
      .nxt_label  (up_label),
      .nxt_row    (up_row),
      .nxt_tflag  (up_tflag),
      .nxt_tlabel (up_tlabel),
      .label      (label_v[s]),
      .row        (row_v[s]),
      .match_a    (match_a_v[s]),
      .match_b    (match_b_v[s]),
      .row_any    (row_any_v[s]),
      .tflag      (tflag_v[s]),
      .tlabel     (tlabel_v[s])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            action_r <= action;
            va_r     <= vertex_a;
            vb_r     <= vertex_b;
            state    <= S_MATCH;
          end
        end

        // every cell compares its label against both endpoints
        S_MATCH: begin
          scan_idx <= '0;
          found_a  <= 1'b0;
          found_b  <= 1'b0;
          status_r <= ST_DONE;
          unique case (action_r) inside
            ACT_ADD_VERTEX: state <= S_UPDATE;
            ACT_DEL_VERTEX, ACT_ADD_EDGE, ACT_DEL_EDGE, ACT_LIST: state <= S_SCAN;
            default: state <= S_FINISH;
          endcase
        end

        // walk the live slots for first and last hits
        S_SCAN: begin
          if (scan_done) begin
            unique case (action_r) inside
              ACT_DEL_VERTEX, ACT_LIST: begin
                if (!found_a) begin
                  status_r <= ST_MISSING;
                  state    <= S_FINISH;
                end else if (action_r == ACT_LIST) begin
                  state <= S_TAP;
                end else begin
                  state <= S_UPDATE;
                end
              end
              default: begin
                if (!(found_a && found_b)) begin
                  status_r <= ST_MISSING;
                  state    <= S_FINISH;
                end else begin
                  state <= S_UPDATE;
                end
              end
            endcase
          end else begin
            if (hit_a) begin
              if (!found_a) first_a <= scan_idx[IW-1:0];
              last_a  <= scan_idx[IW-1:0];
              found_a <= 1'b1;
            end
            if (hit_b) begin
              last_b  <= scan_idx[IW-1:0];
              found_b <= 1'b1;
            end
            scan_idx <= scan_idx + CW'(1);
          end
        end

        S_UPDATE: begin
          if (action_r == ACT_ADD_VERTEX) begin
            if (count == CW'(MAX_NODES)) begin
              status_r <= ST_FULL;
            end else begin
              count <= count + CW'(1);
            end
          end else if (action_r == ACT_DEL_VERTEX) begin
            count <= count - CW'(1);
          end
          state <= S_FINISH;
        end

        // single result beat, edge flag reflects the updated matrix
        S_FINISH: begin
          strobe         <= 1'b1;
          status         <= status_r;
          neighbor_valid <= 1'b0;
          neighbor_label <= '0;
          last           <= 1'b1;
          no_edges       <= graph_empty;
          state          <= S_IDLE;
        end

        // by symmetry each cell's bit at the listed slot marks a neighbor
        S_TAP: state <= S_LIST;

        // neighbor marks drain toward slot 0, one beat per marked slot
        S_LIST: begin
          if (~|tflag_v) begin
            strobe         <= 1'b1;
            status         <= ST_DONE;
            neighbor_valid <= 1'b0;
            neighbor_label <= '0;
            last           <= 1'b1;
            no_edges       <= graph_empty;
            state          <= S_IDLE;
          end else if (tflag_v[0]) begin
            strobe         <= 1'b1;
            status         <= ST_DONE;
            neighbor_valid <= 1'b1;
            neighbor_label <= tlabel_v[0];
            last           <= list_last;
            no_edges       <= graph_empty;
            if (list_last) state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> dv/adjacency_matrix_graph_store_top_tb.sv
`timescale 1ns / 1ps

module adjacency_matrix_graph_store_top_tb;
  import amgs_pkg::*;

  localparam int NODES = 64;
  // codes above the list action are unused and must answer done
  localparam action_t ACT_SPARE_FIRST = ACT_LIST + 3'd1;
  localparam action_t ACT_SPARE_LAST  = 3'd7;
  localparam logic [LABEL_W-1:0] LABEL_MAX  = 32'h7fff_ffff;
  localparam logic [LABEL_W-1:0] LABEL_MIN  = 32'h8000_0000;
  localparam logic [LABEL_W-1:0] LABEL_ONES = 32'hffff_ffff;
  localparam int MAX_SHOWN   = 10;
  // slowest command is a full listing, with its scan and its drain
  localparam int TAIL_CYCLES = 3 * NODES + 16;

  typedef struct {
    action_t            act;
    logic [LABEL_W-1:0] a;
    logic [LABEL_W-1:0] b;
    bit                 drain;   // hold this command until every beat is back
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic               nb_valid;
    logic [LABEL_W-1:0] nb_label;
    logic               is_last;
    logic               no_edges;
  } beat_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  action_t                   action = ACT_ADD_VERTEX;
  logic signed [LABEL_W-1:0] vertex_a = '0;
  logic signed [LABEL_W-1:0] vertex_b = '0;
  logic                      busy;
  logic                      strobe;
  logic [1:0]                status;
  logic                      neighbor_valid;
  logic signed [LABEL_W-1:0] neighbor_label;
  logic                      last;
  logic                      no_edges;

  adjacency_matrix_graph_store_top #(
    .MAX_NODES(NODES)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .vertex_a      (vertex_a),
    .vertex_b      (vertex_b),
    .strobe        (strobe),
    .status        (status),
    .neighbor_valid(neighbor_valid),
    .neighbor_label(neighbor_label),
    .last          (last),
    .no_edges      (no_edges)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ------------------------------------------------------------------
  // graph predictor: own copy of the label list and adjacency matrix
  // ------------------------------------------------------------------
  int                 node_cnt;
  logic [LABEL_W-1:0] node_label [NODES];
  logic [NODES-1:0]   adj_row    [NODES];
  beat_t              expected_beats [$];
  int                 beats_predicted = 0;
  int                 beats_seen = 0;     // written by the monitor only, nonblocking
  int                 bad_beats = 0;

  // first or last live slot holding a label, -1 when absent
  function automatic int find_slot(logic [LABEL_W-1:0] lbl, bit want_last);
    int hit;
    int i;
    hit = -1;
    for (i = 0; i < node_cnt; i++)
      if (node_label[i] == lbl && (want_last || hit < 0)) hit = i;
    return hit;
  endfunction

  // apply one accepted command and queue the beats it must produce
  function automatic void graph_apply(cmd_t c);
    beat_t            outs [$];
    beat_t            bt;
    status_t          st;
    logic [NODES-1:0] keep;
    int               s1;
    int               s2;
    int               r;
    bit               empty;
    st = ST_DONE;
    case (c.act)
      ACT_ADD_VERTEX: begin
        if (node_cnt >= NODES) begin
          st = ST_FULL;
        end else begin
          node_label[node_cnt] = c.a;
          node_cnt++;
        end
      end
      ACT_DEL_VERTEX: begin
        s1 = find_slot(c.a, 1'b0);
        if (s1 < 0) begin
          st = ST_MISSING;
        end else begin
          // close the gap in labels and rows
          for (r = s1; r < node_cnt - 1; r++) begin
            node_label[r] = node_label[r + 1];
            adj_row[r]    = adj_row[r + 1];
          end
          // close the gap in columns
          keep = '0;
          for (r = 0; r < s1; r++) keep[r] = 1'b1;
          for (r = 0; r < node_cnt; r++)
            adj_row[r] = (adj_row[r] & keep) | ((adj_row[r] >> 1) & ~keep);
          // the vacated top slot leaves no edges behind
          adj_row[node_cnt - 1] = '0;
          for (r = 0; r < node_cnt; r++) adj_row[r][node_cnt - 1] = 1'b0;
          node_cnt--;
        end
      end
      ACT_ADD_EDGE, ACT_DEL_EDGE: begin
        s1 = find_slot(c.a, 1'b1);
        s2 = find_slot(c.b, 1'b1);
        if (s1 < 0 || s2 < 0) begin
          st = ST_MISSING;
        end else begin
          adj_row[s1][s2] = (c.act == ACT_ADD_EDGE);
          adj_row[s2][s1] = (c.act == ACT_ADD_EDGE);
        end
      end
      ACT_LIST: begin
        s1 = find_slot(c.a, 1'b0);
        if (s1 < 0) begin
          st = ST_MISSING;
        end else begin
          for (r = 0; r < node_cnt; r++)
            if (adj_row[s1][r]) begin
              bt = '0;
              bt.status   = ST_DONE;
              bt.nb_valid = 1'b1;
              bt.nb_label = node_label[r];
              outs.push_back(bt);
            end
        end
      end
      default: ;
    endcase
    empty = 1'b1;
    for (r = 0; r < node_cnt; r++)
      if (adj_row[r] != '0) empty = 1'b0;
    if (outs.size() == 0) begin
      bt = '0;
      bt.status = st;
      outs.push_back(bt);
    end
    outs[outs.size() - 1].is_last = 1'b1;
    foreach (outs[k]) begin
      outs[k].no_edges = empty;
      expected_beats.push_back(outs[k]);
    end
    beats_predicted += outs.size();
  endfunction

  // ------------------------------------------------------------------
  // command generation, with a label list that tracks the store
  // ------------------------------------------------------------------
  cmd_t               cmd_q [$];
  logic [LABEL_W-1:0] shadow [$];

  function automatic void queue_cmd(action_t act, logic [LABEL_W-1:0] a,
                                    logic [LABEL_W-1:0] b, bit drain);
    cmd_t c;
    int   i;
    c.act   = act;
    c.a     = a;
    c.b     = b;
    c.drain = drain;
    cmd_q.push_back(c);
    case (act)
      ACT_ADD_VERTEX: if (shadow.size() < NODES) shadow.push_back(a);
      ACT_DEL_VERTEX: begin
        for (i = 0; i < shadow.size(); i++)
          if (shadow[i] == a) begin
            shadow.delete(i);
            break;
          end
      end
      default: ;
    endcase
  endfunction

  // small values collide often, wide ones toggle every bit
  function automatic logic [LABEL_W-1:0] fresh_label();
    case ($urandom_range(3))
      0: return LABEL_W'($urandom_range(15)) - LABEL_W'(8);
      1: return $urandom;
      2: begin
        case ($urandom_range(3))
          0: return LABEL_MAX;
          1: return LABEL_MIN;
          2: return LABEL_ONES;
          default: return '0;
        endcase
      end
      default: return {16'h0, 16'($urandom)};
    endcase
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label(int pct_live);
    if (shadow.size() > 0 && $urandom_range(99) < pct_live)
      return shadow[$urandom_range(shadow.size() - 1)];
    return fresh_label();
  endfunction

  // mostly live labels so edges and listings hit, some misses and noise
  function automatic void random_ops(int count);
    int k;
    int roll;
    int add_cut;
    bit drain;
    for (k = 0; k < count; k++) begin
      roll    = $urandom_range(99);
      drain   = ($urandom_range(99) < 2);
      add_cut = (shadow.size() > 32) ? 14 : ((shadow.size() < 4) ? 50 : 28);
      if (roll < add_cut)
        queue_cmd(ACT_ADD_VERTEX, pick_label(20), fresh_label(), drain);
      else if (roll < add_cut + 12)
        queue_cmd(ACT_DEL_VERTEX, pick_label(85), fresh_label(), drain);
      else if (roll < add_cut + 36)
        queue_cmd(ACT_ADD_EDGE, pick_label(92), pick_label(92), drain);
      else if (roll < add_cut + 48)
        queue_cmd(ACT_DEL_EDGE, pick_label(92), pick_label(92), drain);
      else if (roll < 96)
        queue_cmd(ACT_LIST, pick_label(90), fresh_label(), drain);
      else
        queue_cmd(action_t'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST)),
                  $urandom, $urandom, drain);
    end
  endfunction

  // ------------------------------------------------------------------
  // driver: one command beat per start/busy handshake
  // ------------------------------------------------------------------
  cmd_t cur_cmd;
  int   gap_left = 0;
  int   issued = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      // command taken at this edge
      if (start && !busy) graph_apply(cur_cmd);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_q.size() == 0) begin
          start <= 1'b0;
        end else if (cmd_q[0].drain && beats_predicted != beats_seen + int'(strobe)) begin
          // beats still in flight, the one on strobe now is taken at this edge
          start <= 1'b0;
        end else if ((issued < 180 || issued >= 280) && $urandom_range(99) < 8) begin
          // idle a while; commands 180..279 go back to back
          gap_left = $urandom_range(5);
          start <= 1'b0;
        end else begin
          cur_cmd = cmd_q.pop_front();
          issued++;
          start    <= 1'b1;
          action   <= cur_cmd.act;
          vertex_a <= cur_cmd.a;
          vertex_b <= cur_cmd.b;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // monitor: every strobe is a result beat, compared in order
  // ------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    beat_t got;
    beat_t want;
    if (!rst && strobe) begin
      got.status   = status;
      got.nb_valid = neighbor_valid;
      got.nb_label = neighbor_label;
      got.is_last  = last;
      got.no_edges = no_edges;
      beats_seen <= beats_seen + 1;
      if (expected_beats.size() == 0) begin
        bad_beats++;
        if (bad_beats <= MAX_SHOWN)
          $display("%0t unexpected beat: status=%0d valid=%0b label=%h last=%0b no_edges=%0b",
                   $realtime, got.status, got.nb_valid, got.nb_label, got.is_last,
                   got.no_edges);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          bad_beats++;
          if (bad_beats <= MAX_SHOWN)
            $display({"%0t beat mismatch: exp status=%0d valid=%0b label=%h last=%0b ",
                      "no_edges=%0b / got status=%0d valid=%0b label=%h last=%0b no_edges=%0b"},
                     $realtime, want.status, want.nb_valid, want.nb_label, want.is_last,
                     want.no_edges, got.status, got.nb_valid, got.nb_label, got.is_last,
                     got.no_edges);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // stimulus and end of run
  // ------------------------------------------------------------------
  initial begin : stimulus
    int                 j;
    logic [LABEL_W-1:0] hub;
    node_cnt = 0;
    foreach (adj_row[i]) begin
      adj_row[i]    = '0;
      node_label[i] = '0;
    end

    // empty store: every lookup misses
    queue_cmd(ACT_LIST, LABEL_MIN, '0, 1'b0);
    queue_cmd(ACT_DEL_VERTEX, LABEL_MAX, '0, 1'b0);
    queue_cmd(ACT_ADD_EDGE, '0, '0, 1'b0);
    // extreme labels plus a duplicate
    queue_cmd(ACT_ADD_VERTEX, LABEL_MAX, '0, 1'b0);
    queue_cmd(ACT_ADD_VERTEX, LABEL_MIN, LABEL_ONES, 1'b0);
    queue_cmd(ACT_ADD_VERTEX, LABEL_ONES, '0, 1'b0);
    queue_cmd(ACT_ADD_VERTEX, '0, '0, 1'b0);
    queue_cmd(ACT_ADD_VERTEX, LABEL_MAX, '0, 1'b0);
    // no neighbors yet
    queue_cmd(ACT_LIST, LABEL_MIN, '0, 1'b0);
    queue_cmd(ACT_ADD_EDGE, LABEL_MIN, LABEL_ONES, 1'b0);
    // self-loop
    queue_cmd(ACT_ADD_EDGE, LABEL_ONES, LABEL_ONES, 1'b0);
    // duplicate label: the edge lands on the later copy
    queue_cmd(ACT_ADD_EDGE, LABEL_MAX, LABEL_MIN, 1'b0);
    queue_cmd(ACT_LIST, LABEL_ONES, '0, 1'b0);
    // listing uses the first copy, which has no edge
    queue_cmd(ACT_LIST, LABEL_MAX, '0, 1'b0);
    queue_cmd(ACT_DEL_EDGE, LABEL_ONES, LABEL_ONES, 1'b0);
    queue_cmd(ACT_DEL_EDGE, LABEL_MIN, 32'd12345, 1'b0);
    // removal compacts labels, rows and columns
    queue_cmd(ACT_DEL_VERTEX, LABEL_MIN, '0, 1'b0);
    queue_cmd(ACT_LIST, LABEL_ONES, '0, 1'b0);
    queue_cmd(ACT_DEL_VERTEX, LABEL_MAX, '0, 1'b0);
    queue_cmd(ACT_LIST, LABEL_MAX, '0, 1'b0);
    for (j = ACT_SPARE_FIRST; j <= ACT_SPARE_LAST; j++)
      queue_cmd(action_t'(j), LABEL_ONES, LABEL_MIN, 1'b0);
    // a new vertex in the vacated slot starts with no edges
    queue_cmd(ACT_ADD_VERTEX, 32'h5555_aaaa, '0, 1'b1);
    queue_cmd(ACT_LIST, 32'h5555_aaaa, '0, 1'b0);

    random_ops(90);

    // fill the store, then overflow it
    while (shadow.size() < NODES)
      queue_cmd(ACT_ADD_VERTEX, pick_label(3), fresh_label(), 1'b0);
    for (j = 0; j < 3; j++) queue_cmd(ACT_ADD_VERTEX, fresh_label(), '0, 1'b0);
    // hub wired to every slot gives the longest listing
    hub = shadow[$urandom_range(NODES - 1)];
    for (j = 0; j < NODES; j++) queue_cmd(ACT_ADD_EDGE, hub, shadow[j], 1'b0);
    queue_cmd(ACT_LIST, hub, '0, 1'b1);
    for (j = 0; j < 8; j++)
      queue_cmd(ACT_DEL_EDGE, hub, shadow[$urandom_range(NODES - 1)], 1'b0);
    queue_cmd(ACT_LIST, hub, '0, 1'b0);
    for (j = 0; j < 24; j++) queue_cmd(ACT_DEL_VERTEX, pick_label(90), '0, 1'b0);

    random_ops(130);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // settle on the falling edge so driver and monitor have both run
    do @(negedge clk);
    while (cmd_q.size() != 0 || start || expected_beats.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (bad_beats == 0 && expected_beats.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
